// ===== src/svm_pkg.sv =====
package svm_pkg;

	typedef enum logic [5:0] {
		OP_LEA = 6'd0, OP_IMM = 6'd1, OP_JMP = 6'd2, OP_CALL = 6'd3, OP_JZ = 6'd4,
		OP_JNZ = 6'd5, OP_ENT = 6'd6, OP_ADJ = 6'd7, OP_LEV = 6'd8, OP_LI = 6'd9,
		OP_LC = 6'd10, OP_SI = 6'd11, OP_SC = 6'd12, OP_PUSH = 6'd13, OP_OR = 6'd14,
		OP_XOR = 6'd15, OP_AND = 6'd16, OP_EQ = 6'd17, OP_NE = 6'd18, OP_LT = 6'd19,
		OP_GT = 6'd20, OP_LE = 6'd21, OP_GE = 6'd22, OP_SHL = 6'd23, OP_SHR = 6'd24,
		OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27, OP_DIV = 6'd28, OP_MOD = 6'd29,
		OP_EXIT = 6'd37
	} opcode_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EXIT = 3'd1;
	localparam logic [2:0] ST_UNSUP = 3'd2;
	localparam logic [2:0] ST_DIV0 = 3'd3;
	localparam logic [2:0] ST_ADDR = 3'd4;

	typedef struct packed {
		logic [5:0] operation;
		logic signed [63:0] operand;
	} svm_in_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic signed [63:0] acc_value;
		logic [2:0] status;
		logic signed [63:0] exit_value;
	} svm_out_t;

	typedef struct packed {
		logic start;
		logic negate_q;
		logic negate_r;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} svm_div_req_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_RD1, S_EXEC1, S_RD2, S_EXEC2, S_WR, S_DIV, S_DONE
	} state_t;

endpackage

// ===== src/svm_divider.sv =====
module svm_divider
	import svm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input svm_div_req_t req,
	output logic done,
	output logic [63:0] quotient,
	output logic [63:0] remainder
);

	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] dvs_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic nq_q;
	logic nr_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;

	assign rem_sh = {rem_q[62:0], quo_q[63]};
	assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
			nq_q <= req.negate_q;
			nr_q <= req.negate_r;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = nq_q ? (~quo_q + 64'd1) : quo_q;
	assign remainder = nr_q ? (~rem_q + 64'd1) : rem_q;

endmodule

// ===== src/stack_vm_instruction_execute.sv =====
// Executes one instruction of an accumulator-and-stack machine per transfer.
// Raise start with an opcode and operand while busy is low; the instruction is
// taken at that clock edge and busy rises on the next cycle. When it is done,
// done pulses for exactly one cycle with the next program counter, the
// accumulator, a status code and the exit value on result. The receiver cannot
// stall, so the result must be captured in that cycle.
// Each instruction passes through the states RD1, EXEC1 and DONE. CALL, ENT and
// PUSH add WR to write the word memory, LEV adds RD2 and EXEC2 as it reads two
// words, and SI and SC add RD2, EXEC2 and WR, reading the target word before
// writing it. MUL builds its product in the DIV state from the low-by-low,
// low-by-high and high-by-low 32-bit partial products, and DIV and MOD wait
// there for the bit-serial divider that retires one quotient bit a cycle. A new
// instruction can start in the cycle in which done is high, so one instruction
// is in flight. After reset the block clears the word memory one word per
// cycle, holding busy high. The pointers reset to one past the top of memory
// and the accumulator and program counter to zero.
// After an exit or error status the block halts: later instructions change
// nothing and repeat the halt status.
module stack_vm_instruction_execute
	import svm_pkg::*;
#(
	parameter int MEM_WORDS = 4096,
	parameter int CODE_WORDS = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input svm_in_t command,
	output logic busy,
	output logic done,
	output svm_out_t result
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int PW = AW + 4;
	localparam int PCW = ($clog2(CODE_WORDS) > 12) ? $clog2(CODE_WORDS) : 12;
	localparam logic [63:0] MEM_BYTES = 64'(MEM_WORDS) * 64'd8;
	localparam logic [63:0] CODE_LIM = 64'(CODE_WORDS);
	localparam logic signed [63:0] STEP_MAX = 64'(MEM_WORDS) + 64'sd2;

	logic [63:0] mem [MEM_WORDS];
	logic [63:0] rdata_q;
	logic [AW-1:0] raddr;
	logic ren;
	logic [AW-1:0] waddr;
	logic [63:0] wdata;
	logic wen;

	state_t state_q, state_d;
	logic [63:0] acc_q;
	logic [PW-1:0] sp_q, bp_q;
	logic [PCW-1:0] pc_q;
	logic halted_q;
	logic [2:0] hcode_q;
	logic [63:0] hexit_q;
	logic [AW:0] clr_q;
	logic [5:0] op_q;
	logic [63:0] opd_q;
	logic [63:0] tmp_q;
	logic [63:0] tos_q;
	svm_out_t res_q;

	logic [AW-1:0] waddr_q;
	logic [63:0] wdata_q;

	svm_div_req_t dreq;
	logic ddone;
	logic [63:0] dquo, drem;

	logic [1:0] mcnt_q;
	logic [63:0] macc_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mprod;

	svm_divider u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq),
		.done(ddone), .quotient(dquo), .remainder(drem)
	);

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		if (ren) rdata_q <= mem[raddr];
	end

	function automatic logic word_ok(input logic [63:0] a);
		return a[2:0] == 3'd0 && a < MEM_BYTES && a + 64'd8 <= MEM_BYTES;
	endfunction

	function automatic logic [AW-1:0] widx(input logic [63:0] a);
		return a[AW+2:3];
	endfunction

	logic [63:0] sp64, bp64, n1, n2, pc_p1, pc_p2;
	assign sp64 = 64'(sp_q);
	assign bp64 = 64'(bp_q);
	assign pc_p1 = 64'(pc_q) + 64'd1;
	assign pc_p2 = 64'(pc_q) + 64'd2;
	assign n1 = (pc_p1 >= CODE_LIM) ? pc_p1 - CODE_LIM : pc_p1;
	assign n2 = (pc_p2 >= CODE_LIM) ? pc_p2 - CODE_LIM : pc_p2;

	assign mul_a = (mcnt_q == 2'd2) ? tos_q[63:32] : tos_q[31:0];
	assign mul_b = (mcnt_q == 2'd1) ? acc_q[63:32] : acc_q[31:0];
	assign mprod = 64'(mul_a) * 64'(mul_b);

	// Next-state register values computed combinationally at commit time.
	logic commit;
	logic [2:0] st_c;
	logic [63:0] acc_c, ev_c, npc_c, sp_c, bp_c;
	logic do_wr;
	logic [AW-1:0] wa_c;
	logic [63:0] wd_c;
	logic go_rd2;
	logic [AW-1:0] ra2_c;
	logic go_div;
	logic [63:0] tos_n;
	logic signed [63:0] t_s;
	logic [63:0] sh_w;
	logic [7:0] bsel;
	logic [5:0] amt;

	always_comb begin
		state_d = state_q;
		commit = 1'b0;
		st_c = ST_OK;
		acc_c = acc_q;
		ev_c = '0;
		npc_c = n1;
		sp_c = sp64;
		bp_c = bp64;
		do_wr = 1'b0;
		wa_c = '0;
		wd_c = '0;
		go_rd2 = 1'b0;
		ra2_c = '0;
		go_div = 1'b0;
		ren = 1'b0;
		raddr = widx(sp64);
		wen = 1'b0;
		waddr = waddr_q;
		wdata = wdata_q;
		dreq = '0;
		tos_n = rdata_q;
		t_s = '0;
		sh_w = '0;
		bsel = '0;
		amt = acc_q[5:0];
		case (state_q)
			S_CLEAR: begin
				wen = 1'b1;
				waddr = clr_q[AW-1:0];
				wdata = '0;
				if (clr_q == (AW+1)'(MEM_WORDS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_RD1;
				end
			end
			S_RD1: begin
				ren = 1'b1;
				case (op_q)
					OP_LEV: raddr = widx(bp64);
					OP_LI, OP_LC: raddr = widx(acc_q);
					default: raddr = widx(sp64);
				endcase
				state_d = S_EXEC1;
			end
			S_EXEC1, S_EXEC2: begin
				if (halted_q) begin
					state_d = S_DONE;
				end else begin
					commit = 1'b1;
					if (op_q inside {[6'd14:6'd29]}) begin
						if (!word_ok(sp64)) st_c = ST_ADDR;
						else sp_c = sp64 + 64'd8;
					end
					if (st_c == ST_OK) begin
						case (op_q)
							OP_LEA: begin acc_c = bp64 + (opd_q << 3); npc_c = n2; end
							OP_IMM: begin acc_c = opd_q; npc_c = n2; end
							OP_JMP, OP_JZ, OP_JNZ: begin
								npc_c = n2;
								if (op_q == OP_JMP || (op_q == OP_JZ && acc_q == 0) ||
									(op_q == OP_JNZ && acc_q != 0)) begin
									if (opd_q >= CODE_LIM) st_c = ST_ADDR;
									else npc_c = opd_q;
								end
							end
							OP_CALL: begin
								if (opd_q >= CODE_LIM || sp64 < 64'd8 || sp64 > MEM_BYTES)
									st_c = ST_ADDR;
								else begin
									sp_c = sp64 - 64'd8;
									do_wr = 1'b1; wa_c = widx(sp_c); wd_c = n2;
									npc_c = opd_q;
								end
							end
							OP_ENT: begin
								t_s = $signed(sp64) - 64'sd8 - $signed(opd_q << 3);
								if ($signed(opd_q) < -STEP_MAX || $signed(opd_q) > STEP_MAX ||
									sp64 < 64'd8 || sp64 > MEM_BYTES || t_s < 0 ||
									t_s > $signed(MEM_BYTES))
									st_c = ST_ADDR;
								else begin
									do_wr = 1'b1; wa_c = widx(sp64 - 64'd8); wd_c = bp64;
									bp_c = sp64 - 64'd8; sp_c = t_s; npc_c = n2;
								end
							end
							OP_ADJ: begin
								t_s = $signed(sp64) + $signed(opd_q << 3);
								if ($signed(opd_q) < -STEP_MAX || $signed(opd_q) > STEP_MAX ||
									t_s < 0 || t_s > $signed(MEM_BYTES))
									st_c = ST_ADDR;
								else begin sp_c = t_s; npc_c = n2; end
							end
							OP_LEV: begin
								if (!word_ok(bp64) || !word_ok(bp64 + 64'd8)) st_c = ST_ADDR;
								else if (state_q == S_EXEC1) begin
									commit = 1'b0; go_rd2 = 1'b1; ra2_c = widx(bp64 + 64'd8);
								end else if (tmp_q[2:0] != 3'd0 || tmp_q > MEM_BYTES ||
									rdata_q >= CODE_LIM)
									st_c = ST_ADDR;
								else begin
									sp_c = bp64 + 64'd16; bp_c = tmp_q; npc_c = rdata_q;
								end
							end
							OP_LI: begin
								if (!word_ok(acc_q)) st_c = ST_ADDR;
								else acc_c = rdata_q;
							end
							OP_LC: begin
								if (acc_q >= MEM_BYTES) st_c = ST_ADDR;
								else begin
									sh_w = rdata_q >> {acc_q[2:0], 3'b000};
									acc_c = {{56{sh_w[7]}}, sh_w[7:0]};
								end
							end
							OP_SI, OP_SC: begin
								if (!word_ok(sp64)) st_c = ST_ADDR;
								else if (state_q == S_EXEC1) begin
									if (op_q == OP_SI ? !word_ok(rdata_q) : rdata_q >= MEM_BYTES)
										st_c = ST_ADDR;
									else begin
										commit = 1'b0; go_rd2 = 1'b1; ra2_c = widx(rdata_q);
									end
								end else begin
									sp_c = sp64 + 64'd8;
									do_wr = 1'b1; wa_c = widx(tmp_q);
									if (op_q == OP_SI) wd_c = acc_q;
									else begin
										bsel = acc_q[7:0];
										wd_c = (rdata_q & ~(64'hFF << {tmp_q[2:0], 3'b000})) |
											(64'(bsel) << {tmp_q[2:0], 3'b000});
										acc_c = {{56{bsel[7]}}, bsel};
									end
								end
							end
							OP_PUSH: begin
								if (sp64 < 64'd8 || sp64 > MEM_BYTES) st_c = ST_ADDR;
								else begin
									sp_c = sp64 - 64'd8;
									do_wr = 1'b1; wa_c = widx(sp_c); wd_c = acc_q;
								end
							end
							OP_OR: acc_c = tos_n | acc_q;
							OP_XOR: acc_c = tos_n ^ acc_q;
							OP_AND: acc_c = tos_n & acc_q;
							OP_EQ: acc_c = 64'(tos_n == acc_q);
							OP_NE: acc_c = 64'(tos_n != acc_q);
							OP_LT: acc_c = 64'($signed(tos_n) < $signed(acc_q));
							OP_GT: acc_c = 64'($signed(tos_n) > $signed(acc_q));
							OP_LE: acc_c = 64'($signed(tos_n) <= $signed(acc_q));
							OP_GE: acc_c = 64'($signed(tos_n) >= $signed(acc_q));
							OP_SHL: acc_c = tos_n << amt;
							OP_SHR: acc_c = 64'($signed(tos_n) >>> amt);
							OP_ADD: acc_c = tos_n + acc_q;
							OP_SUB: acc_c = tos_n - acc_q;
							OP_MUL: begin
								commit = 1'b0; go_div = 1'b1;
							end
							OP_DIV, OP_MOD: begin
								if (acc_q == 0) st_c = ST_DIV0;
								else if (tos_n == 64'h8000_0000_0000_0000 && acc_q == '1)
									acc_c = (op_q == OP_DIV) ? tos_n : 64'd0;
								else begin
									commit = 1'b0; go_div = 1'b1;
									dreq.start = 1'b1;
									dreq.dividend = tos_n[63] ? ~tos_n + 64'd1 : tos_n;
									dreq.divisor = acc_q[63] ? ~acc_q + 64'd1 : acc_q;
									dreq.negate_q = tos_n[63] ^ acc_q[63];
									dreq.negate_r = tos_n[63];
								end
							end
							OP_EXIT: begin
								if (!word_ok(sp64)) st_c = ST_ADDR;
								else begin ev_c = rdata_q; st_c = ST_EXIT; end
							end
							default: st_c = ST_UNSUP;
						endcase
					end
					if (go_rd2) begin
						ren = 1'b1; raddr = ra2_c; state_d = S_RD2;
					end else if (go_div) begin
						state_d = S_DIV;
					end else begin
						state_d = do_wr && st_c == ST_OK ? S_WR : S_DONE;
					end
				end
			end
			S_RD2: state_d = S_EXEC2;
			S_WR: begin
				wen = 1'b1;
				state_d = S_DONE;
			end
			S_DIV: begin
				commit = 1'b1;
				if (op_q == OP_MUL) begin
					if (mcnt_q == 2'd2) begin
						acc_c = macc_q + {mprod[31:0], 32'd0};
						sp_c = sp64 + 64'd8;
						state_d = S_DONE;
					end else commit = 1'b0;
				end else if (ddone) begin
					acc_c = (op_q == OP_DIV) ? dquo : drem;
					sp_c = sp64 + 64'd8;
					state_d = S_DONE;
				end else commit = 1'b0;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			acc_q <= '0;
			sp_q <= PW'(MEM_BYTES);
			bp_q <= PW'(MEM_BYTES);
			pc_q <= '0;
			halted_q <= 1'b0;
			hcode_q <= '0;
			hexit_q <= '0;
			res_q <= '0;
			mcnt_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			mcnt_q <= (state_q == S_DIV) ? mcnt_q + 2'd1 : 2'd0;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_DONE) done <= 1'b1;
			if ((state_q == S_EXEC1 || state_q == S_EXEC2) && halted_q) begin
				res_q <= '{12'(pc_q), acc_q, hcode_q, hexit_q};
			end
			if (commit) begin
				if (st_c == ST_OK || st_c == ST_EXIT) begin
					acc_q <= acc_c;
					sp_q <= PW'(sp_c);
					bp_q <= PW'(bp_c);
					pc_q <= PCW'(npc_c);
					res_q <= '{12'(npc_c), acc_c, st_c, ev_c};
				end else begin
					res_q <= '{12'(pc_q), acc_q, st_c, 64'd0};
				end
				if (st_c != ST_OK) begin
					halted_q <= 1'b1;
					hcode_q <= st_c;
					hexit_q <= (st_c == ST_EXIT) ? ev_c : 64'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= command.operation;
			opd_q <= command.operand;
		end
		if (state_q == S_EXEC1) begin
			tmp_q <= rdata_q;
			tos_q <= rdata_q;
		end
		if (state_q == S_DIV) begin
			macc_q <= (mcnt_q == 2'd0) ? mprod : macc_q + {mprod[31:0], 32'd0};
		end
		if (commit && do_wr) begin
			waddr_q <= wa_c;
			wdata_q <= wd_c;
		end
	end

	assign busy = state_q != S_IDLE;
	assign result = res_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
	import svm_pkg::*;
();

	localparam logic [63:0] MEM_BYTES = 64'd32768;
	localparam logic [63:0] CODE_SIZE = 64'd4096;
	localparam int WATCHDOG_LIMIT = 20000;

	class svm_scoreboard;
		logic [63:0] acc;
		logic [63:0] sp;
		logic [63:0] bp;
		logic [11:0] pc;
		logic [63:0] mem [4096];
		bit halted;
		logic [2:0] halt_status;
		logic [63:0] halt_value;
		svm_out_t expected_q[$];
		int errors;

		function new();
			acc = '0;
			sp = MEM_BYTES;
			bp = MEM_BYTES;
			pc = '0;
			foreach (mem[i]) mem[i] = '0;
			halted = 0;
			halt_status = ST_OK;
			halt_value = '0;
			errors = 0;
		endfunction

		function bit word_ok(logic [63:0] a);
			return a[2:0] == 3'd0 && a < MEM_BYTES;
		endfunction

		function svm_out_t execute(logic [5:0] op, logic [63:0] raw, bit commit);
			logic [63:0] a, s, b, tos, ev, nbp, ret, w, addr, wdata;
			logic [11:0] npc, n1, n2;
			logic [2:0] st;
			longint x, y, t;
			bit take, wr, ok;
			int widx;
			svm_out_t r;
			if (halted) begin
				r.next_pc = pc;
				r.acc_value = acc;
				r.status = halt_status;
				r.exit_value = halt_value;
				return r;
			end
			a = acc;
			s = sp;
			b = bp;
			n1 = pc + 12'd1;
			n2 = pc + 12'd2;
			npc = n1;
			st = ST_OK;
			ev = '0;
			tos = '0;
			wr = 0;
			widx = 0;
			wdata = '0;
			if (op >= OP_OR && op <= OP_MOD) begin
				if (!word_ok(s)) begin
					st = ST_ADDR;
				end else begin
					tos = mem[s[14:3]];
					s = s + 64'd8;
				end
			end
			if (st == ST_OK) begin
				case (op)
					OP_LEA: begin
						a = b + (raw << 3);
						npc = n2;
					end
					OP_IMM: begin
						a = raw;
						npc = n2;
					end
					OP_JMP, OP_JZ, OP_JNZ: begin
						take = op == OP_JMP || (op == OP_JZ && a == 0) || (op == OP_JNZ && a != 0);
						npc = n2;
						if (take) begin
							if (raw >= CODE_SIZE) st = ST_ADDR;
							else npc = raw[11:0];
						end
					end
					OP_CALL: begin
						if (raw >= CODE_SIZE || s < 8 || s > MEM_BYTES) begin
							st = ST_ADDR;
						end else begin
							s = s - 64'd8;
							wr = 1;
							widx = s[14:3];
							wdata = 64'(n2);
							npc = raw[11:0];
						end
					end
					OP_ENT: begin
						x = $signed(raw);
						if (x < -4098 || x > 4098 || s < 8 || s > MEM_BYTES) begin
							st = ST_ADDR;
						end else begin
							t = longint'(s) - 8 - x * 8;
							if (t < 0 || t > 32768) begin
								st = ST_ADDR;
							end else begin
								wr = 1;
								addr = s - 64'd8;
								widx = addr[14:3];
								wdata = b;
								b = s - 64'd8;
								s = t;
								npc = n2;
							end
						end
					end
					OP_ADJ: begin
						x = $signed(raw);
						t = longint'(s) + x * 8;
						if (x < -4098 || x > 4098 || t < 0 || t > 32768) begin
							st = ST_ADDR;
						end else begin
							s = t;
							npc = n2;
						end
					end
					OP_LEV: begin
						if (!word_ok(b) || !word_ok(b + 64'd8)) begin
							st = ST_ADDR;
						end else begin
							nbp = mem[b[14:3]];
							addr = b + 64'd8;
							ret = mem[addr[14:3]];
							if (nbp[2:0] != 3'd0 || nbp > MEM_BYTES || ret >= CODE_SIZE) begin
								st = ST_ADDR;
							end else begin
								s = b + 64'd16;
								b = nbp;
								npc = ret[11:0];
							end
						end
					end
					OP_LI: begin
						if (!word_ok(a)) st = ST_ADDR;
						else a = mem[a[14:3]];
					end
					OP_LC: begin
						if (a >= MEM_BYTES) begin
							st = ST_ADDR;
						end else begin
							w = mem[a[14:3]];
							w = w >> (a[2:0] * 8);
							a = {{56{w[7]}}, w[7:0]};
						end
					end
					OP_SI, OP_SC: begin
						if (!word_ok(s)) begin
							st = ST_ADDR;
						end else begin
							addr = mem[s[14:3]];
							if (op == OP_SI) begin
								if (!word_ok(addr)) begin
									st = ST_ADDR;
								end else begin
									wr = 1;
									widx = addr[14:3];
									wdata = a;
								end
							end else begin
								if (addr >= MEM_BYTES) begin
									st = ST_ADDR;
								end else begin
									w = mem[addr[14:3]];
									w[addr[2:0] * 8 +: 8] = a[7:0];
									wr = 1;
									widx = addr[14:3];
									wdata = w;
									a = {{56{a[7]}}, a[7:0]};
								end
							end
							if (st == ST_OK) s = s + 64'd8;
						end
					end
					OP_PUSH: begin
						if (s < 8 || s > MEM_BYTES) begin
							st = ST_ADDR;
						end else begin
							s = s - 64'd8;
							wr = 1;
							widx = s[14:3];
							wdata = a;
						end
					end
					OP_OR: a = tos | a;
					OP_XOR: a = tos ^ a;
					OP_AND: a = tos & a;
					OP_EQ: a = 64'(tos == a);
					OP_NE: a = 64'(tos != a);
					OP_LT: a = 64'($signed(tos) < $signed(a));
					OP_GT: a = 64'($signed(tos) > $signed(a));
					OP_LE: a = 64'($signed(tos) <= $signed(a));
					OP_GE: a = 64'($signed(tos) >= $signed(a));
					OP_SHL: a = tos << a[5:0];
					OP_SHR: a = $signed(tos) >>> a[5:0];
					OP_ADD: a = tos + a;
					OP_SUB: a = tos - a;
					OP_MUL: a = tos * a;
					OP_DIV, OP_MOD: begin
						x = $signed(tos);
						y = $signed(a);
						if (y == 0) st = ST_DIV0;
						else if (tos == {1'b1, 63'd0} && y == -1) a = (op == OP_DIV) ? tos : 64'd0;
						else a = (op == OP_DIV) ? x / y : x % y;
					end
					OP_EXIT: begin
						if (!word_ok(s)) begin
							st = ST_ADDR;
						end else begin
							ev = mem[s[14:3]];
							st = ST_EXIT;
						end
					end
					default: st = ST_UNSUP;
				endcase
			end
			ok = st == ST_OK || st == ST_EXIT;
			if (!ok) ev = '0;
			r.next_pc = ok ? npc : pc;
			r.acc_value = ok ? a : acc;
			r.status = st;
			r.exit_value = ev;
			if (commit) begin
				if (ok) begin
					acc = a;
					sp = s;
					bp = b;
					pc = npc;
					if (wr) mem[widx] = wdata;
				end
				if (st != ST_OK) begin
					halted = 1;
					halt_status = st;
					halt_value = ev;
				end
			end
			return r;
		endfunction

		function void note_command(svm_in_t c);
			expected_q.push_back(execute(c.operation, c.operand, 1));
		endfunction

		function void check_result(svm_out_t got);
			svm_out_t e;
			if (expected_q.size() == 0) begin
				$error("result with no instruction outstanding");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.next_pc !== e.next_pc) begin
				$error("next_pc: expected %0d, actual %0d", e.next_pc, got.next_pc);
				errors++;
			end
			if (got.acc_value !== e.acc_value) begin
				$error("acc_value: expected %0h, actual %0h", e.acc_value, got.acc_value);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
			if (got.exit_value !== e.exit_value) begin
				$error("exit_value: expected %0h, actual %0h", e.exit_value, got.exit_value);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	svm_in_t command;
	logic busy;
	logic done;
	svm_out_t result;

	svm_scoreboard vm_check;
	svm_scoreboard vm_plan;
	int idle_cycles;
	bit no_gaps;

	stack_vm_instruction_execute i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) vm_check.note_command(command);
			if (done) vm_check.check_result(result);
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	function logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	task automatic issue(logic [5:0] op, logic [63:0] opd, bit allow_fault);
		svm_out_t r;
		int gap;
		r = vm_plan.execute(op, opd, 0);
		if (!allow_fault && r.status != ST_OK) begin
			op = OP_IMM;
			opd = random_word();
		end
		void'(vm_plan.execute(op, opd, 1));
		command <= '{operation: op, operand: opd};
		start <= 1'b1;
		do @(posedge clk); while (busy);
		gap = gap_length();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (vm_check.expected_q.size() != 0) @(posedge clk);
	endtask

	function logic [63:0] operand_for(logic [5:0] op);
		case (op)
			OP_IMM: begin
				case ($urandom_range(0, 4))
					0: return 64'($urandom_range(0, 4095)) << 3;
					1: return 64'($urandom_range(0, 32767));
					2: return random_word();
					3: return 64'($urandom_range(0, 80)) - 64'd16;
					default: begin
						case ($urandom_range(0, 3))
							0: return 64'd0;
							1: return '1;
							2: return {1'b1, 63'd0};
							default: return {1'b0, {63{1'b1}}};
						endcase
					end
				endcase
			end
			OP_JMP, OP_JZ, OP_JNZ, OP_CALL:
				return ($urandom_range(0, 9) == 0) ? random_word() : 64'($urandom_range(0, 4095));
			OP_ENT, OP_ADJ: return 64'($urandom_range(0, 12)) - 64'd6;
			OP_LEA: return ($urandom_range(0, 3) == 0) ? random_word() : 64'($urandom_range(0, 20)) - 64'd10;
			default: return random_word();
		endcase
	endfunction

	task automatic random_instruction();
		logic [5:0] op;
		logic [63:0] opd;
		svm_out_t r;
		for (int k = 0; k < 20; k++) begin
			op = 6'($urandom_range(OP_LEA, OP_MOD));
			opd = operand_for(op);
			r = vm_plan.execute(op, opd, 0);
			if (r.status == ST_OK) break;
		end
		issue(op, opd, 0);
	endtask

	initial begin
		int count;
		int n;
		vm_check = new();
		vm_plan = new();
		idle_cycles = 0;
		no_gaps = 0;
		arst_n = 1'b0;
		start = 1'b0;
		command = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		issue(OP_IMM, {1'b1, 63'd0}, 0);
		issue(OP_PUSH, 0, 0);
		issue(OP_IMM, '1, 0);
		issue(OP_DIV, 0, 0);
		issue(OP_PUSH, 0, 0);
		issue(OP_IMM, '1, 0);
		issue(OP_MOD, 0, 0);
		issue(OP_IMM, {1'b1, 63'd1}, 0);
		issue(OP_PUSH, 0, 0);
		issue(OP_IMM, 64'd63, 0);
		issue(OP_SHR, 0, 0);
		issue(OP_PUSH, 0, 0);
		issue(OP_IMM, 64'd127, 0);
		issue(OP_SHL, 0, 0);
		issue(OP_IMM, 64'd13, 0);
		issue(OP_PUSH, 0, 0);
		issue(OP_IMM, 64'hF0, 0);
		issue(OP_SC, 0, 0);
		issue(OP_IMM, 64'd13, 0);
		issue(OP_LC, 0, 0);
		issue(OP_JMP, 64'd4095, 0);
		issue(OP_CALL, 64'd100, 0);
		issue(OP_ENT, 64'd2, 0);
		issue(OP_LEA, '1, 0);
		issue(OP_LEV, 0, 0);

		count = 0;
		while (count < 900) begin
			no_gaps = count >= 200 && count < 300;
			if (count >= 450 && count < 460) drain();
			if ($urandom_range(0, 9) == 0) begin
				issue(OP_CALL, 64'($urandom_range(0, 4095)), 0);
				issue(OP_ENT, 64'($urandom_range(0, 4)), 0);
				n = $urandom_range(0, 6);
				repeat (n) random_instruction();
				issue(OP_LEV, 0, 0);
				count += n + 3;
			end else begin
				random_instruction();
				count++;
			end
		end
		no_gaps = 0;

		case ($urandom_range(0, 3))
			0: issue(($urandom_range(0, 1) != 0) ? 6'($urandom_range(OP_MOD + 1, OP_EXIT - 1))
				: 6'($urandom_range(OP_EXIT + 1, 63)), random_word(), 1);
			1: begin
				issue(OP_PUSH, 0, 0);
				issue(OP_IMM, 0, 0);
				issue(OP_DIV, 0, 1);
			end
			2: begin
				issue(OP_IMM, 64'd1, 0);
				issue(OP_LI, 0, 1);
			end
			default: begin
				issue(OP_PUSH, 0, 0);
				issue(OP_EXIT, 0, 1);
			end
		endcase
		repeat (12) issue(6'($urandom_range(0, 63)), random_word(), 1);
		issue(6'd63, '1, 1);

		drain();
		repeat (100) @(posedge clk);
		if (vm_check.errors == 0 && vm_check.expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
